FILE: sv/md5sh_pkg.sv
// Shared types, constants and round tables for the MD5 stream hasher.
package md5sh_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'h3F;

  typedef struct packed {
    logic start;    // begin compression of the buffered block
    logic iv_load;  // return chaining words to the initial vector
  } md5sh_ctrl_t;

  // Sine-derived additive constant for step i.
  function automatic logic [31:0] md5sh_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left-rotate amount for step i.
  function automatic logic [4:0] md5sh_rot(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word index used by step i.
  function automatic logic [3:0] md5sh_g(input logic [5:0] i);
    logic [3:0] n;
    logic [3:0] g;
    n = i[3:0];
    case (i[5:4])
      2'd0:    g = n;
      2'd1:    g = 4'((n << 2) + n + 4'd1);
      2'd2:    g = 4'((n << 1) + n + 4'd5);
      2'd3:    g = 4'((n << 3) - n);
      default: g = n;
    endcase
    return g;
  endfunction

  // Round-dependent boolean function.
  function automatic logic [31:0] md5sh_f(input logic [1:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (rnd)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      2'd3:    f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

FILE: sv/md5sh_buf.sv
// 64-byte block buffer: byte writes, one 32-bit little-endian word read per cycle.
module md5sh_buf
  import md5sh_pkg::*;
(
  input  logic        clk,
  input  logic        we,
  input  logic [5:0]  waddr,
  input  logic [7:0]  wdata,
  input  logic [3:0]  raddr,
  output logic [31:0] rdata
);

  for (genvar ln = 0; ln < 4; ln++) begin : g_lane
    logic [7:0] lane_mem [16];
    logic [7:0] rd_r;

    always_ff @(posedge clk) begin
      if (we && (waddr[1:0] == 2'(ln))) begin
        lane_mem[waddr[5:2]] <= wdata;
      end
      rd_r <= lane_mem[raddr];
    end

    assign rdata[8*ln +: 8] = rd_r;
  end

endmodule

FILE: sv/md5sh_core.sv
// Iterative MD5 compression: one shared step datapath, a sum and a rotate state per step.
module md5sh_core
  import md5sh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  md5sh_ctrl_t       ctrl,
  input  logic [31:0]       rdata,
  output logic [3:0]        raddr,
  output logic              busy,
  output logic [3:0][31:0]  chain
);

  typedef enum logic [2:0] {C_IDLE, C_LOAD, C_SUM, C_ROT, C_FIN} cst_t;

  cst_t             state_r;
  logic [5:0]       step_r;
  logic [31:0]      a_r, b_r, c_r, d_r, sum_r;
  logic [3:0][31:0] h_r;

  logic [5:0]  step_rd;
  logic [4:0]  sh;
  logic [63:0] rot_w;
  logic [31:0] b_new;

  // During the rotate phase the next step's word is already fetched.
  assign step_rd = (state_r == C_ROT) ? 6'(step_r + 6'd1) : step_r;
  assign raddr   = md5sh_g(step_rd);
  assign sh      = md5sh_rot(step_r);
  assign rot_w   = {sum_r, sum_r} << sh;
  assign b_new   = b_r + rot_w[63:32];
  assign busy    = (state_r != C_IDLE);
  assign chain   = h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      step_r  <= 6'd0;
      h_r     <= {IV_D, IV_C, IV_B, IV_A};
    end else begin
      case (state_r)
        C_IDLE: begin
          if (ctrl.iv_load) begin
            h_r <= {IV_D, IV_C, IV_B, IV_A};
          end
          if (ctrl.start) begin
            a_r     <= h_r[0];
            b_r     <= h_r[1];
            c_r     <= h_r[2];
            d_r     <= h_r[3];
            step_r  <= 6'd0;
            state_r <= C_LOAD;
          end
        end
        C_LOAD: begin
          state_r <= C_SUM;
        end
        C_SUM: begin
          sum_r   <= a_r + md5sh_f(step_r[5:4], b_r, c_r, d_r) + md5sh_k(step_r) + rdata;
          state_r <= C_ROT;
        end
        C_ROT: begin
          a_r    <= d_r;
          d_r    <= c_r;
          c_r    <= b_r;
          b_r    <= b_new;
          step_r <= 6'(step_r + 6'd1);
          state_r <= (step_r == BLOCK_LAST) ? C_FIN : C_SUM;
        end
        C_FIN: begin
          h_r[0]  <= h_r[0] + a_r;
          h_r[1]  <= h_r[1] + b_r;
          h_r[2]  <= h_r[2] + c_r;
          h_r[3]  <= h_r[3] + d_r;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/md5_stream_hasher.sv
// Top level of the MD5 stream hasher: byte intake, padding sequencer, digest output.
//
// Channel | Dir | Handshake          | Payload
// --------+-----+--------------------+----------------------------------------------
// in_     | in  | in_tvalid/tready   | tdata=msg_byte, tuser=has_byte, tlast=eom
// out_    | out | out_tvalid/tready  | tdata=digest_word, tuser=word_index, tlast=last
//
// A word carrying a byte is taken while the block stays ready, except the one that
// fills the 64-byte block: that one is followed by a compression (64 steps, each a
// sum and a rotate state on the shared step unit, plus load and fold-in). A closing
// word adds the pad bytes (up to 64, or 72 across two blocks) and one or two
// compressions, then four digest words, one per output handshake.
// Reset (synchronous, active low) restores the initial vector and a zero length.
// in_tready is low while padding, compressing or presenting the digest; the digest
// words hold in the output register for as long as out_tready stays low.
module md5_stream_hasher
  import md5sh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast   // last_word
);

  typedef enum logic [1:0] {S_IDLE, S_PAD, S_COMP, S_OUT} st_t;

  st_t         state_r;
  logic [5:0]  pos_r;      // fill position in the block
  logic [60:0] len_r;      // message length in bytes (bit length = len_r * 8)
  logic        first_r;    // next pad byte is the 0x80 mark
  logic        lenok_r;    // positions 56..63 of this block take the length
  logic        fin_r;      // running compression is the last one
  logic        pad_r;      // padding resumes after the running compression
  logic [1:0]  idx_r;
  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;

  md5sh_ctrl_t      core_ctrl;
  logic             core_busy;
  logic [3:0][31:0] chain;
  logic [3:0]       raddr;
  logic [31:0]      rdata;

  logic        in_fire, out_fire;
  logic        buf_we;
  logic [7:0]  buf_wdata;
  logic [7:0]  pad_byte;
  logic [63:0] bit_len;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_tvalid_r && out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = idx_r;
  assign out_tlast  = (idx_r == 2'd3);

  // Length field goes out low byte first.
  assign bit_len = {len_r, 3'b000};

  always_comb begin
    if (first_r) begin
      pad_byte = PAD_MARK;
    end else if (lenok_r && (pos_r >= LEN_POS)) begin
      pad_byte = bit_len[8*pos_r[2:0] +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign buf_we    = (in_fire && in_tuser) || (state_r == S_PAD);
  assign buf_wdata = (state_r == S_PAD) ? pad_byte : in_tdata;

  assign core_ctrl.start   = buf_we && (pos_r == BLOCK_LAST);
  assign core_ctrl.iv_load = (state_r == S_OUT) && out_fire && (idx_r == 2'd3);

  md5sh_buf u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (pos_r),
    .wdata (buf_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  md5sh_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (core_ctrl),
    .rdata (rdata),
    .raddr (raddr),
    .busy  (core_busy),
    .chain (chain)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_r        <= 6'd0;
      len_r        <= '0;
      first_r      <= 1'b0;
      lenok_r      <= 1'b0;
      fin_r        <= 1'b0;
      pad_r        <= 1'b0;
      idx_r        <= 2'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            first_r <= 1'b1;
            lenok_r <= 1'b0;
            fin_r   <= 1'b0;
            pad_r   <= in_tlast;
            if (in_tuser) begin
              pos_r <= 6'(pos_r + 6'd1);
              len_r <= 61'(len_r + 61'd1);
              if (pos_r == BLOCK_LAST) begin
                state_r <= S_COMP;
              end else if (in_tlast) begin
                state_r <= S_PAD;
              end
            end else if (in_tlast) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pos_r   <= 6'(pos_r + 6'd1);
          first_r <= 1'b0;
          if (first_r && (pos_r < LEN_POS)) begin
            lenok_r <= 1'b1;
          end
          if (pos_r == BLOCK_LAST) begin
            fin_r   <= lenok_r && !first_r;
            pad_r   <= 1'b1;
            state_r <= S_COMP;
          end
        end
        S_COMP: begin
          // Core raises busy the cycle after start and drops it once the
          // chaining words hold the folded-in result.
          if (!core_busy) begin
            if (!pad_r) begin
              state_r <= S_IDLE;
            end else if (fin_r) begin
              out_tvalid_r <= 1'b1;
              out_tdata_r  <= chain[0];
              idx_r        <= 2'd0;
              state_r      <= S_OUT;
            end else begin
              lenok_r <= 1'b1;
              state_r <= S_PAD;
            end
          end
        end
        S_OUT: begin
          if (out_fire) begin
            if (idx_r == 2'd3) begin
              out_tvalid_r <= 1'b0;
              idx_r        <= 2'd0;
              len_r        <= '0;
              pad_r        <= 1'b0;
              fin_r        <= 1'b0;
              state_r      <= S_IDLE;
            end else begin
              idx_r       <= 2'(idx_r + 2'd1);
              out_tdata_r <= chain[2'(idx_r + 2'd1)];
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Input and output sides never open at once.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while digest pending");

  // Compression runs only while the sequencer waits for it.
  a_core_owned: assert property (@(posedge clk) disable iff (!rst_n)
    core_busy |-> (state_r == S_COMP))
    else $error("core busy outside compression state");

  // Digest appears only on a block boundary.
  a_digest_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (pos_r == 6'd0) && (out_tuser == 2'd0))
    else $error("digest started off block boundary");

  // After the last digest word the block is ready for a new message.
  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_tlast) |=> (in_tready && !out_tvalid && (len_r == '0)))
    else $error("block not idle after last digest word");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for md5_stream_hasher: directed vectors plus random messages.
`timescale 1ns / 100ps

module tb;
  import md5sh_pkg::*;

  // Run-length knobs.
  localparam int RAND_ITEMS  = 420;   // words offered in the random part
  localparam int HOLD_AT     = 36;    // digest word count at which the sink backs off
  localparam int HOLD_CYCLES = 400;   // length of that back-off
  localparam int DRAIN       = 300;   // quiet cycles after the last digest word
  localparam int STALL_LIMIT = 5000;  // cycles with no handshake before giving up

  // Known digests, {A, B, C, D} as the block emits them (low byte of A is first).
  localparam logic [127:0] EMPTY_DIG = 128'hd98c1dd4_04b2008f_980980e9_7e42f8ec;
  localparam logic [127:0] A_DIG     = 128'hb975c10c_a8b6f1c0_e299c331_61267769;
  localparam logic [127:0] ABC_DIG   = 128'h98500190_b04fd23c_7d3f96d6_727fe128;

  // Additive constants, one per step.
  localparam logic [31:0] SINE_T [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {round, step mod 4}.
  localparam int ROT_T [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // One row of the directed table. has_dig marks rows whose digest is typed in.
  typedef struct packed {
    logic [7:0]   msg;
    logic         has_byte;
    logic         eom;
    logic         has_dig;
    logic [127:0] dig;
  } stim_row_t;

  localparam int DIR_ROWS = 16;
  localparam stim_row_t DIR_TBL [DIR_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIG},  // empty message straight out of reset
    '{8'hFF, 1'b0, 1'b0, 1'b0, 128'h0},     // no byte, no end mark: ignored
    '{8'h61, 1'b1, 1'b1, 1'b1, A_DIG},      // "a", byte and end mark together
    '{8'h61, 1'b1, 1'b0, 1'b0, 128'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 128'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 128'h0},     // ignored word mid-message
    '{8'h63, 1'b1, 1'b0, 1'b0, 128'h0},
    '{8'h00, 1'b0, 1'b1, 1'b1, ABC_DIG},    // "abc", closed by an empty word
    '{8'h00, 1'b1, 1'b0, 1'b0, 128'h0},     // byte extremes
    '{8'hFF, 1'b1, 1'b0, 1'b0, 128'h0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 128'h0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 128'h0},
    '{8'h55, 1'b1, 1'b0, 1'b0, 128'h0},
    '{8'hAA, 1'b1, 1'b1, 1'b0, 128'h0},
    '{8'hA5, 1'b0, 1'b1, 1'b1, EMPTY_DIG},  // end mark without has_byte drops the data
    '{8'h5A, 1'b1, 1'b1, 1'b0, 128'h0}
  };

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] msg_byte
  logic        in_tuser = 1'b0;    // [0] has_byte
  logic        in_tlast = 1'b0;    // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] digest_word
  logic [1:0]  out_tuser;          // [1:0] word_index
  logic        out_tlast;          // last_word

  // Digest words still owed by the block, oldest first.
  digest_exp_t digest_q [$];
  int          err_cnt = 0;
  bit          tx_burst = 1'b0;   // sender offers back to back while set
  bit          rx_burst = 1'b0;   // sink stays ready while set

  // Predictor state: chaining words, block buffer, running bit count.
  logic [31:0] chain [4];
  logic [7:0]  blk_buf [64];
  logic [63:0] msg_bits;

  md5_stream_hasher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 64-step compression of blk_buf, folded into the chaining words.
  function automatic void md5_compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t, sum;
    int          g, s;
    for (int i = 0; i < 16; i++) begin
      m[i] = {blk_buf[4*i+3], blk_buf[4*i+2], blk_buf[4*i+1], blk_buf[4*i]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      s   = ROT_T[(i / 16) * 4 + (i % 4)];
      sum = a + f + SINE_T[i] + m[g];
      t   = d;
      d   = c;
      c   = b;
      b   = b + ((sum << s) | (sum >> (32 - s)));
      a   = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endfunction

  // Store one byte at the fill position; a full block is compressed at once.
  function automatic void md5_absorb(input logic [7:0] v);
    blk_buf[msg_bits[8:3]] = v;
    msg_bits = msg_bits + 64'd8;
    if (msg_bits[8:3] == 6'd0) md5_compress();
  endfunction

  // Applies one accepted word; returns 1 with the digest {A,B,C,D} when it closes a message.
  function automatic bit md5_predict(input logic [7:0] v, input logic hb, input logic eom,
                                     output logic [127:0] dig);
    logic [63:0] len;
    dig = '0;
    if (hb) md5_absorb(v);
    if (!eom) return 1'b0;
    // pad: marker, zeros up to offset 56, then the length low byte first
    len = msg_bits;
    md5_absorb(PAD_MARK);
    while (msg_bits[8:3] != LEN_POS) md5_absorb(8'h00);
    for (int k = 0; k < 8; k++) md5_absorb(len[8*k +: 8]);
    dig = {chain[0], chain[1], chain[2], chain[3]};
    chain[0] = IV_A;
    chain[1] = IV_B;
    chain[2] = IV_C;
    chain[3] = IV_D;
    msg_bits = '0;
    return 1'b1;
  endfunction

  // Offer one input word, wait for its handshake, then queue the digest it owes.
  // in_tvalid stays high afterwards so that back-to-back words need no gap.
  task automatic send_word(input logic [7:0] v, input logic hb, input logic eom,
                           input logic has_dig, input logic [127:0] typed_dig);
    int           gap;
    bit           closed;
    logic [127:0] dig;
    digest_exp_t  e;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= hb;
    in_tlast  <= eom;
    do @(posedge clk); while (!in_tready);
    closed = md5_predict(v, hb, eom, dig);
    if (closed) begin
      // typed digests take precedence; the predictor still tracks the state
      if (has_dig) dig = typed_dig;
      for (int k = 0; k < 4; k++) begin
        e.word = dig[127 - 32*k -: 32];
        e.idx  = 2'(k);
        e.last = (k == 3);
        digest_q.push_back(e);
      end
    end
  endtask

  // Stimulus: reset, directed table, random messages, drain, verdict.
  initial begin : stim
    int len, sel, sent, msgs;
    bit with_byte;
    chain[0] = IV_A;
    chain[1] = IV_B;
    chain[2] = IV_C;
    chain[3] = IV_D;
    msg_bits = '0;
    for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
    sent = 0;
    msgs = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_word(DIR_TBL[r].msg, DIR_TBL[r].has_byte, DIR_TBL[r].eom,
                DIR_TBL[r].has_dig, DIR_TBL[r].dig);
    end

    // Random messages; lengths cluster around the padding edges (55, 56, 63, 64)
    // and the two-block case, with a few runs of several blocks.
    while (sent < RAND_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)      len = $urandom_range(0, 8);
      else if (sel < 7) len = $urandom_range(50, 70);
      else if (sel < 9) len = $urandom_range(9, 49);
      else              len = $urandom_range(100, 135);
      with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      tx_burst  = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < len; j++) begin
        // stray empty words inside the message
        if ($urandom_range(0, 9) == 0) begin
          send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 128'h0);
          sent++;
        end
        send_word(8'($urandom_range(0, 255)), 1'b1, with_byte && (j == len - 1),
                  1'b0, 128'h0);
        sent++;
      end
      if (!with_byte) begin
        send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 128'h0);
        sent++;
      end
      msgs++;
      // one pause with the input quiet until every digest word is out
      if (msgs == 2) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (digest_q.size() != 0);
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
    // late or extra digest words still get flagged by the sink
    repeat (DRAIN) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Sink: random ready gaps, one long back-off, field checks on every digest word.
  initial begin : sink
    int          gap, seen;
    digest_exp_t e;
    seen = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (seen % 4 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 3);
      // long back-off while the sender keeps going: the block must stall its input
      if (seen == HOLD_AT) gap = HOLD_CYCLES;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      seen++;
      if (digest_q.size() == 0) begin
        $error("unexpected digest word: data %h index %0d last %0b",
               out_tdata, out_tuser, out_tlast);
        err_cnt++;
      end else begin
        e = digest_q.pop_front();
        if (out_tdata !== e.word) begin
          $error("digest_word: expected %h, got %h", e.word, out_tdata);
          err_cnt++;
        end
        if (out_tuser !== e.idx) begin
          $error("word_index: expected %0d, got %0d", e.idx, out_tuser);
          err_cnt++;
        end
        if (out_tlast !== e.last) begin
          $error("last_word: expected %0b, got %0b", e.last, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: too long without a handshake on either side means a hang.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb NOT OK");
    $finish;
  end

endmodule
